[rtl/core/csvt_pkg.sv]
`default_nettype none
package csvt_pkg;

  localparam int FIELD_LIMIT_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 6;

  localparam logic [KIND_W-1:0] EV_VALUE      = 3'd0;
  localparam logic [KIND_W-1:0] EV_FIELD_END  = 3'd1;
  localparam logic [KIND_W-1:0] EV_RECORD_END = 3'd2;
  localparam logic [KIND_W-1:0] EV_INPUT_END  = 3'd3;
  localparam logic [KIND_W-1:0] EV_MALFORMED  = 3'd4;

  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [IDX_W-1:0]  idx;
  } event_t;

  // one entry per input beat that produced results
  typedef struct packed {
    logic   two;
    event_t ev0;
    event_t ev1;
  } pkt_t;

endpackage
`default_nettype wire

[rtl/core/csvt_in_if.sv]
`default_nettype none
interface csvt_in_if;
  logic                          valid;
  logic                          ready;
  logic [csvt_pkg::BYTE_W-1:0]   data_byte;
  logic                          end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

[rtl/core/csvt_out_if.sv]
`default_nettype none
interface csvt_out_if;
  logic                          valid;
  logic                          ready;
  logic [csvt_pkg::KIND_W-1:0]   event_kind;
  logic [csvt_pkg::BYTE_W-1:0]   value_byte;
  logic [csvt_pkg::IDX_W-1:0]    field_index;
  logic                          last_of_run;

  modport source (output valid, output event_kind, output value_byte, output field_index,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input value_byte, input field_index,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/core/csv_field_tokenizer_unit.sv]
// csv field tokenizer
// in_ch: one text byte per beat (data_byte), or an end-of-input beat with
//   end_of_text set; data_byte is then ignored
// out_ch: event beats (value byte, field end, record end, input end, malformed)
//   with the unescaped byte, field index and last_of_run on the final beat of
//   each input beat; input beats that give no event give no output beat
// each input beat gives zero, one or two output beats; end of input always
//   gives an input-end beat last and returns the parser to its reset state
// path: the classify logic writes the event queue at the edge that takes an
//   input beat; the back end loads the output register from the queue head
//   when the register is empty or its beat is being taken
// throughput: one input beat per cycle while output is taken; a beat with two
//   events takes the output register twice, and the queue of
//   QUEUE_DEPTH entries absorbs that until it fills
// receiver stall: out_ch holds its beat; the parser keeps taking input until
//   the queue is full, then drops in_ch.ready
// reset: synchronous, active low on rst_n; clears parser state, queue and
//   output valid; no clearing pass is needed
`default_nettype none
module csv_field_tokenizer_unit #(
  parameter int FIELD_LIMIT = csvt_pkg::FIELD_LIMIT_DEF,
  parameter int QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  csvt_in_if.sink    in_ch,
  csvt_out_if.source out_ch
);

  logic           q_push, q_pop, q_full, q_nonempty;
  csvt_pkg::pkt_t q_pkt, q_head;

  csvt_front #(.FIELD_LIMIT(FIELD_LIMIT)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_pkt  (q_pkt)
  );

  csvt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (q_pkt),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

[rtl/core/csvt_front.sv]
`default_nettype none
module csvt_front #(
  parameter int FIELD_LIMIT = csvt_pkg::FIELD_LIMIT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  csvt_in_if.sink        in_ch,
  input  wire logic      q_full,
  output logic           q_push,
  output csvt_pkg::pkt_t q_pkt
);

  localparam int CW = $clog2(FIELD_LIMIT);
  localparam int XW = (CW > csvt_pkg::IDX_W) ? CW : csvt_pkg::IDX_W;

  localparam logic [2:0] MODE_START      = 3'd0;
  localparam logic [2:0] MODE_UNQUOTED   = 3'd1;
  localparam logic [2:0] MODE_QUOTED     = 3'd2;
  localparam logic [2:0] MODE_QUOTE_SEEN = 3'd3;
  localparam logic [2:0] MODE_CR_SEEN    = 3'd4;
  localparam logic [2:0] MODE_MALFORMED  = 3'd5;

  logic [2:0]    mode_r, mode_nxt;
  logic          open_r, open_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                          accept;
  logic [csvt_pkg::BYTE_W-1:0]   b;
  logic [XW-1:0]                 cnt_x;
  logic [csvt_pkg::IDX_W-1:0]    idx;
  logic                          at_limit;
  logic do_malf, do_fend, do_rend, do_value, pre_ev;
  csvt_pkg::event_t              pre;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;
  assign cnt_x       = XW'(cnt_r);
  assign idx         = cnt_x[csvt_pkg::IDX_W-1:0];
  assign at_limit    = ({1'b0, cnt_r} + (CW+1)'(1)) >= (CW+1)'(FIELD_LIMIT);

  always_comb begin
    mode_nxt = mode_r;
    open_nxt = open_r;
    cnt_nxt  = cnt_r;
    do_malf  = 1'b0;
    do_fend  = 1'b0;
    do_rend  = 1'b0;
    do_value = 1'b0;
    pre_ev   = 1'b0;
    pre      = '0;
    q_pkt    = '0;
    q_push   = 1'b0;
    if (in_ch.end_of_text) begin
      case (mode_r)
        MODE_MALFORMED: pre_ev = 1'b0;
        MODE_QUOTED, MODE_CR_SEEN: begin
          pre_ev   = 1'b1;
          pre.kind = csvt_pkg::EV_MALFORMED;
        end
        MODE_UNQUOTED, MODE_QUOTE_SEEN: begin
          pre_ev   = 1'b1;
          pre.kind = csvt_pkg::EV_RECORD_END;
        end
        default: begin
          pre_ev   = open_r;
          pre.kind = csvt_pkg::EV_RECORD_END;
        end
      endcase
      pre.idx = idx;
      if (pre_ev) begin
        q_pkt.two      = 1'b1;
        q_pkt.ev0      = pre;
        q_pkt.ev1.kind = csvt_pkg::EV_INPUT_END;
      end else begin
        q_pkt.ev0.kind = csvt_pkg::EV_INPUT_END;
      end
      q_push   = accept;
      mode_nxt = MODE_START;
      open_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (mode_r != MODE_MALFORMED) begin
      open_nxt = 1'b1;
      if (b == csvt_pkg::CH_NUL) begin
        do_malf = 1'b1;
      end else begin
        case (mode_r)
          MODE_UNQUOTED: begin
            if (b == csvt_pkg::CH_QUOTE) do_malf = 1'b1;
            else if (b == csvt_pkg::CH_COMMA) do_fend = 1'b1;
            else if (b == csvt_pkg::CH_LF) do_rend = 1'b1;
            else if (b == csvt_pkg::CH_CR) mode_nxt = MODE_CR_SEEN;
            else do_value = 1'b1;
          end
          MODE_QUOTED: begin
            if (b == csvt_pkg::CH_QUOTE) mode_nxt = MODE_QUOTE_SEEN;
            else if (b == csvt_pkg::CH_LF || b == csvt_pkg::CH_CR) do_malf = 1'b1;
            else do_value = 1'b1;
          end
          MODE_QUOTE_SEEN: begin
            if (b == csvt_pkg::CH_QUOTE) begin
              do_value = 1'b1;
              mode_nxt = MODE_QUOTED;
            end else if (b == csvt_pkg::CH_COMMA) do_fend = 1'b1;
            else if (b == csvt_pkg::CH_LF) do_rend = 1'b1;
            else if (b == csvt_pkg::CH_CR) mode_nxt = MODE_CR_SEEN;
            else do_malf = 1'b1;
          end
          MODE_CR_SEEN: begin
            if (b == csvt_pkg::CH_LF) do_rend = 1'b1;
            else do_malf = 1'b1;
          end
          default: begin
            if (b == csvt_pkg::CH_QUOTE) mode_nxt = MODE_QUOTED;
            else if (b == csvt_pkg::CH_COMMA) do_fend = 1'b1;
            else if (b == csvt_pkg::CH_LF) do_rend = 1'b1;
            else if (b == csvt_pkg::CH_CR) mode_nxt = MODE_CR_SEEN;
            else begin
              do_value = 1'b1;
              mode_nxt = MODE_UNQUOTED;
            end
          end
        endcase
      end
      q_pkt.ev0.idx = idx;
      if (do_malf || (do_fend && at_limit)) begin
        q_pkt.ev0.kind = csvt_pkg::EV_MALFORMED;
        mode_nxt       = MODE_MALFORMED;
        q_push         = accept;
      end else if (do_fend) begin
        q_pkt.ev0.kind = csvt_pkg::EV_FIELD_END;
        cnt_nxt        = cnt_r + CW'(1);
        mode_nxt       = MODE_START;
        q_push         = accept;
      end else if (do_rend) begin
        q_pkt.ev0.kind = csvt_pkg::EV_RECORD_END;
        cnt_nxt        = '0;
        open_nxt       = 1'b0;
        mode_nxt       = MODE_START;
        q_push         = accept;
      end else if (do_value) begin
        q_pkt.ev0.kind  = csvt_pkg::EV_VALUE;
        q_pkt.ev0.value = b;
        q_push          = accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
      open_r <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      open_r <= open_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.end_of_text |=> mode_r == MODE_START && cnt_r == '0 && !open_r)
    else $error("state not cleared after end of input");
  a_eot_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.end_of_text |-> q_push)
    else $error("end of input produced no entry");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(cnt_r) < (CW+1)'(FIELD_LIMIT))
    else $error("field counter past limit");
`endif

endmodule
`default_nettype wire

[rtl/core/csvt_queue.sv]
`default_nettype none
module csvt_queue #(
  parameter int DEPTH = csvt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire csvt_pkg::pkt_t  push_pkt,
  input  wire logic            pop,
  output logic                 full,
  output logic                 nonempty,
  output csvt_pkg::pkt_t       head
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  csvt_pkg::pkt_t mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;

  assign full     = cnt_r == NW'(DEPTH);
  assign nonempty = cnt_r != '0;
  assign head     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    rp_nxt  = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + NW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_nxt;
      if (pop) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_pkt;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
    else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= NW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[rtl/core/csvt_back.sv]
`default_nettype none
module csvt_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_nonempty,
  input  wire csvt_pkg::pkt_t  q_head,
  output logic                 q_pop,
  csvt_out_if.source           out_ch
);

  logic                          valid_r;
  logic                          half_r, half_nxt;
  logic                          load;
  csvt_pkg::event_t              ev_r, ev_nxt;
  logic                          last_r, last_nxt;

  assign load = (!valid_r || out_ch.ready) && q_nonempty;

  always_comb begin
    half_nxt = half_r;
    q_pop    = 1'b0;
    if (half_r) begin
      ev_nxt   = q_head.ev1;
      last_nxt = 1'b1;
      if (load) begin
        half_nxt = 1'b0;
        q_pop    = 1'b1;
      end
    end else begin
      ev_nxt   = q_head.ev0;
      last_nxt = !q_head.two;
      if (load) begin
        half_nxt = q_head.two;
        q_pop    = !q_head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      half_r <= half_nxt;
      if (load) valid_r <= 1'b1;
      else if (out_ch.ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r   <= ev_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.event_kind  = ev_r.kind;
  assign out_ch.value_byte  = ev_r.value;
  assign out_ch.field_index = ev_r.idx;
  assign out_ch.last_of_run = last_r;

`ifndef SYNTHESIS
  a_half_has_head: assert property (@(posedge clk) disable iff (!rst_n) half_r |-> q_nonempty)
    else $error("second beat pending with empty queue");
  a_half_follows: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> valid_r && !last_r)
    else $error("second beat pending without first beat shown");
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> load && last_nxt)
    else $error("entry popped before its final beat");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import csvt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_LIMIT  = 10;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_UNQUOTED,
    SCAN_QUOTED,
    SCAN_QUOTE_SEEN,
    SCAN_CR_SEEN,
    SCAN_MALFORMED
  } scan_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } token_t;

  logic clk;
  logic rst_n;

  csvt_in_if  in_ch();
  csvt_out_if out_ch();

  csv_field_tokenizer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scan_mode_e scan_mode;
  bit         record_open;
  int         field_count;

  token_t pending_tokens[$];
  token_t step_tokens[$];

  int send_idle_pct;
  int recv_idle_pct;
  int useful_beats;
  int stream_count;
  int record_count;
  int malformed_count;
  int checked_tokens;
  int mismatch_count;
  int cycle_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // tokenizer prediction
  function automatic void add_token(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] value,
                                    int idx);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.idx   = IDX_W'(idx);
    t.last  = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic void flag_malformed();
    add_token(EV_MALFORMED, '0, field_count);
    scan_mode = SCAN_MALFORMED;
    malformed_count++;
  endfunction

  function automatic void close_field();
    if (field_count + 1 >= FIELD_LIMIT_DEF) begin
      flag_malformed();
    end else begin
      add_token(EV_FIELD_END, '0, field_count);
      field_count++;
      scan_mode = SCAN_START;
    end
  endfunction

  function automatic void close_record();
    add_token(EV_RECORD_END, '0, field_count);
    field_count = 0;
    record_open = 1'b0;
    scan_mode = SCAN_START;
    record_count++;
  endfunction

  function automatic void clear_parser();
    scan_mode = SCAN_START;
    record_open = 1'b0;
    field_count = 0;
  endfunction

  function automatic void tokenize_beat(logic [BYTE_W-1:0] b, logic eot);
    step_tokens.delete();
    if (eot) begin
      case (scan_mode)
        SCAN_MALFORMED: begin
        end
        SCAN_QUOTED, SCAN_CR_SEEN: begin
          add_token(EV_MALFORMED, '0, field_count);
          malformed_count++;
        end
        SCAN_UNQUOTED, SCAN_QUOTE_SEEN: begin
          add_token(EV_RECORD_END, '0, field_count);
          record_count++;
        end
        default: begin
          if (record_open) begin
            add_token(EV_RECORD_END, '0, field_count);
            record_count++;
          end
        end
      endcase
      add_token(EV_INPUT_END, '0, 0);
      clear_parser();
      stream_count++;
    end else if (scan_mode != SCAN_MALFORMED) begin
      record_open = 1'b1;
      if (b == CH_NUL) begin
        flag_malformed();
      end else begin
        case (scan_mode)
          SCAN_UNQUOTED: begin
            if (b == CH_QUOTE) flag_malformed();
            else if (b == CH_COMMA) close_field();
            else if (b == CH_LF) close_record();
            else if (b == CH_CR) scan_mode = SCAN_CR_SEEN;
            else add_token(EV_VALUE, b, field_count);
          end
          SCAN_QUOTED: begin
            if (b == CH_QUOTE) scan_mode = SCAN_QUOTE_SEEN;
            else if (b == CH_LF || b == CH_CR) flag_malformed();
            else add_token(EV_VALUE, b, field_count);
          end
          SCAN_QUOTE_SEEN: begin
            if (b == CH_QUOTE) begin
              add_token(EV_VALUE, b, field_count);
              scan_mode = SCAN_QUOTED;
            end else if (b == CH_COMMA) close_field();
            else if (b == CH_LF) close_record();
            else if (b == CH_CR) scan_mode = SCAN_CR_SEEN;
            else flag_malformed();
          end
          SCAN_CR_SEEN: begin
            if (b == CH_LF) close_record();
            else flag_malformed();
          end
          default: begin
            if (b == CH_QUOTE) scan_mode = SCAN_QUOTED;
            else if (b == CH_COMMA) close_field();
            else if (b == CH_LF) close_record();
            else if (b == CH_CR) scan_mode = SCAN_CR_SEEN;
            else begin
              add_token(EV_VALUE, b, field_count);
              scan_mode = SCAN_UNQUOTED;
            end
          end
        endcase
      end
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
  endfunction

  // one input beat, with random idle cycles in front
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    if (eot || scan_mode != SCAN_MALFORMED) useful_beats++;
    tokenize_beat(b, eot);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic end_input();
    send_beat(BYTE_W'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_text_byte(bit quoted);
    logic [BYTE_W-1:0] c;
    do begin
      if ($urandom_range(3) != 0) c = BYTE_W'($urandom_range(32, 126));
      else c = BYTE_W'($urandom_range(1, 255));
    end while (c == CH_CR || c == CH_LF ||
               (!quoted && (c == CH_QUOTE || c == CH_COMMA)));
    return c;
  endfunction

  task automatic test_quoted_fields();
    send_text("a,\"b\"\"c\",\"\"\r\n");
    send_text("\n");
    send_beat(8'hff, 1'b0);
    send_beat(CH_COMMA, 1'b0);
    send_beat(8'h01, 1'b0);
    end_input();
  endtask

  task automatic test_malformed_input();
    send_text("\rx");
    end_input();
    send_text("a\"b");
    end_input();
    send_text("\"\n");
    end_input();
    send_text("\"a\"b");
    end_input();
    send_beat(CH_NUL, 1'b0);
    end_input();
    send_text("\"a");
    end_input();
    send_text("\r");
    end_input();
    end_input();
  endtask

  task automatic test_field_limit();
    repeat (FIELD_LIMIT_DEF - 1) send_beat(CH_COMMA, 1'b0);
    send_beat(CH_LF, 1'b0);
    repeat (FIELD_LIMIT_DEF) send_beat(CH_COMMA, 1'b0);
    end_input();
  endtask

  task automatic test_random_streams(input int target);
    logic [BYTE_W-1:0] text[$];
    logic [BYTE_W-1:0] c;
    int start_beats;
    int n_records;
    int n_fields;
    int len;
    bit quoted;
    start_beats = useful_beats;
    while (useful_beats - start_beats < target) begin
      text.delete();
      n_records = $urandom_range(1, 4);
      for (int r = 0; r < n_records; r++) begin
        if ($urandom_range(9) == 0) text.insert(text.size(), CH_LF);
        n_fields = ($urandom_range(14) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++) begin
          if (f > 0) text.insert(text.size(), CH_COMMA);
          len = (n_fields > 8) ? $urandom_range(0, 1) : $urandom_range(0, 6);
          quoted = ($urandom_range(2) == 0);
          if (quoted) text.insert(text.size(), CH_QUOTE);
          for (int k = 0; k < len; k++) begin
            c = pick_text_byte(quoted);
            text.insert(text.size(), c);
            if (c == CH_QUOTE) text.insert(text.size(), c);
          end
          if (quoted) text.insert(text.size(), CH_QUOTE);
        end
        if (r < n_records - 1 || $urandom_range(1) == 0) begin
          if ($urandom_range(1) == 0) text.insert(text.size(), CH_CR);
          text.insert(text.size(), CH_LF);
        end
      end
      // broken text: stray bytes and a dangling quote or carriage return
      foreach (text[i]) begin
        if ($urandom_range(39) == 0) text[i] = BYTE_W'($urandom_range(255));
      end
      if ($urandom_range(11) == 0)
        text.insert(text.size(), ($urandom_range(1) == 0) ? CH_CR : CH_QUOTE);
      foreach (text[i]) begin
        send_beat(text[i], 1'b0);
        if (scan_mode == SCAN_MALFORMED && $urandom_range(3) != 0) break;
      end
      end_input();
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      checked_tokens++;
      if (pending_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("unexpected beat: kind %0d value %02h index %0d last %0b",
                   out_ch.event_kind, out_ch.value_byte, out_ch.field_index,
                   out_ch.last_of_run);
      end else begin
        want = pending_tokens.pop_front();
        if (out_ch.event_kind !== want.kind || out_ch.value_byte !== want.value ||
            out_ch.field_index !== want.idx || out_ch.last_of_run !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("mismatch: expected kind %0d value %02h index %0d last %0b, got kind %0d value %02h index %0d last %0b",
                     want.kind, want.value, want.idx, want.last,
                     out_ch.event_kind, out_ch.value_byte, out_ch.field_index,
                     out_ch.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 51;
    useful_beats = 0;
    stream_count = 0;
    record_count = 0;
    malformed_count = 0;
    checked_tokens = 0;
    mismatch_count = 0;
    cycle_count = 0;
    clear_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_quoted_fields();
    test_malformed_input();
    test_field_limit();
    test_random_streams(300);

    send_idle_pct = 51;
    recv_idle_pct = 24;
    test_random_streams(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(300);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d input beats in %0d text streams, %0d records closed, %0d malformed",
             useful_beats, stream_count, record_count, malformed_count);
    $display("checked %0d output beats, %0d mismatches", checked_tokens, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/csvt_pkg.sv
rtl/core/csvt_in_if.sv
rtl/core/csvt_out_if.sv
rtl/core/csvt_front.sv
rtl/core/csvt_queue.sv
rtl/core/csvt_back.sv
rtl/core/csv_field_tokenizer_unit.sv
bench/tb_top.sv
